// ===== rtl/core/uab_pkg.sv =====
// shared types and constants for the uart auto-baud detector
package uab_pkg;

  localparam int COUNT_WIDTH_DEF      = 16;
  localparam int SETTLE_BIT_TIMES_DEF = 8;

  localparam int DIV_W    = 13;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 32;
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 16;

  localparam logic [DIV_W-1:0] DIV_MAX = 13'h1fff;
  localparam logic [CFG_W-1:0] TIMEOUT_RESET = 32'd26214400;

  // divisor rounding: shift amount and keep bit per speed mode
  localparam int SHIFT_DS = 3;
  localparam int KEEP_DS  = 2;
  localparam int SHIFT_NS = 4;
  localparam int KEEP_NS  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT_TICKS = 2'd0,
    REG_DOUBLE_SPEED  = 2'd1
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_SHORT   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_HIGH = 3'd1,
    PH_WAIT_LOW  = 3'd2,
    PH_MEAS_A    = 3'd3,
    PH_WAIT_LOW2 = 3'd4,
    PH_MEAS_B    = 3'd5,
    PH_SETTLE    = 3'd6,
    PH_DONE      = 3'd7
  } phase_t;

endpackage

// ===== rtl/core/uart_autobaud_detector.sv =====
// uart auto-baud detector top level: line sampling, pulse timing, divisor output
//
// Usage: one item on s_* carries one sample of the receive line (rx_level) and
// a restart flag. After restart (or reset) the block waits, with a timeout of
// timeout_ticks high samples, for the line to go low, resyncs on high then low,
// times two low pulses of the sync character 0x55 and keeps the shorter one.
// After about SETTLE_BIT_TIMES further bit times it emits one item on m_*
// with a divisor and a status, then ignores the line until restart.
// The result item goes to the output register (skid register while stalled).
// Throughput: one sample per cycle while s_tready is high; all phase logic
// sits between the state registers and the output register.
// Configuration writes on cfg_* take effect at the next edge; write them only
// while the block is idle.
// Reset restores the register defaults and starts a new detection.
// When m_tready stays low a second result is held in a skid register; s_tready
// drops only while that skid register is full.
module uart_autobaud_detector
  import uab_pkg::*;
#(
  parameter int COUNT_WIDTH      = COUNT_WIDTH_DEF,
  parameter int SETTLE_BIT_TIMES = SETTLE_BIT_TIMES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // [0] rx_level, [1] restart, rest zero
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // [12:0] divisor, [14:13] status, rest zero
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int SETTLE_W = COUNT_WIDTH + $clog2(SETTLE_BIT_TIMES);
  localparam int XW       = (COUNT_WIDTH > DIV_W) ? COUNT_WIDTH : DIV_W + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // configuration
  logic [CFG_W-1:0] timeout_ticks;
  logic             double_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      double_speed  <= 1'b1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        REG_DOUBLE_SPEED:  double_speed  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // run state
  phase_t                  phase, phase_next;
  logic [CFG_W-1:0]        timeout_count, timeout_count_next;
  logic [COUNT_WIDTH-1:0]  pulse_count, pulse_count_next;
  logic [COUNT_WIDTH-1:0]  first_width, first_width_next;
  logic [SETTLE_W-1:0]     settle_count, settle_count_next;

  logic accept;
  logic high;
  logic restart;

  assign accept  = s_tvalid && s_tready;
  assign high    = s_tdata[0];
  assign restart = s_tdata[1];

  // state as seen this item, after an optional restart
  phase_t                 ph;
  logic [CFG_W-1:0]       tc;
  logic [COUNT_WIDTH-1:0] pc;
  logic [COUNT_WIDTH-1:0] fw;
  logic [SETTLE_W-1:0]    sc;

  assign ph = restart ? PH_IDLE : phase;
  assign tc = restart ? '0 : timeout_count;
  assign pc = restart ? '0 : pulse_count;
  assign fw = restart ? '0 : first_width;
  assign sc = restart ? '0 : settle_count;

  logic [CFG_W-1:0]       tc_inc;
  logic [COUNT_WIDTH-1:0] pc_inc;
  logic [SETTLE_W-1:0]    sc_inc;
  logic [SETTLE_W-1:0]    settle_target;
  logic                   timed_out;
  logic                   settled;

  assign tc_inc        = (tc == '1) ? tc : tc + 1'b1;
  assign pc_inc        = (pc == CNT_MAX) ? pc : pc + 1'b1;
  assign sc_inc        = sc + 1'b1;
  assign settle_target = SETTLE_W'(fw) * SETTLE_W'(SETTLE_BIT_TIMES);
  assign timed_out     = high && (tc_inc >= timeout_ticks);
  assign settled       = sc_inc >= settle_target;

  // next phase
  always_comb begin
    phase_next = ph;
    case (ph)
      PH_IDLE: begin
        if (!high) begin
          phase_next = PH_WAIT_HIGH;
        end else if (timed_out) begin
          phase_next = PH_DONE;
        end
      end
      PH_WAIT_HIGH: if (high) phase_next = PH_WAIT_LOW;
      PH_WAIT_LOW:  if (!high) phase_next = PH_MEAS_A;
      PH_MEAS_A:    if (high) phase_next = PH_WAIT_LOW2;
      PH_WAIT_LOW2: if (!high) phase_next = PH_MEAS_B;
      PH_MEAS_B:    if (high) phase_next = PH_SETTLE;
      PH_SETTLE:    if (settled) phase_next = PH_DONE;
      default:      phase_next = ph;
    endcase
  end

  // divisor from the kept bit time
  logic [COUNT_WIDTH-1:0] shifted;
  logic                   keep;
  logic [COUNT_WIDTH-1:0] rounded;
  logic [XW-1:0]          rounded_x;
  logic [DIV_W-1:0]       div_sat;
  logic                   too_short;

  assign shifted   = double_speed ? (fw >> SHIFT_DS) : (fw >> SHIFT_NS);
  assign keep      = double_speed ? fw[KEEP_DS] : fw[KEEP_NS];
  assign too_short = !keep && (shifted == '0);
  assign rounded   = keep ? shifted : shifted - 1'b1;
  assign rounded_x = XW'(rounded);
  assign div_sat   = (rounded_x > XW'(DIV_MAX)) ? DIV_MAX : DIV_W'(rounded_x);

  // counters and result
  logic             res_valid;
  logic [DIV_W-1:0] res_divisor;
  status_t          res_status;

  always_comb begin
    timeout_count_next = tc;
    pulse_count_next   = pc;
    first_width_next   = fw;
    settle_count_next  = sc;
    res_valid          = 1'b0;
    res_divisor        = '0;
    res_status         = ST_OK;
    case (ph)
      PH_IDLE: begin
        if (high) begin
          timeout_count_next = tc_inc;
          if (timed_out) begin
            res_valid  = 1'b1;
            res_status = ST_TIMEOUT;
          end
        end
      end
      PH_WAIT_LOW, PH_WAIT_LOW2: begin
        if (!high) pulse_count_next = COUNT_WIDTH'(1);
      end
      PH_MEAS_A: begin
        if (!high) begin
          pulse_count_next = pc_inc;
        end else begin
          first_width_next = pc;
          pulse_count_next = '0;
        end
      end
      PH_MEAS_B: begin
        if (!high) begin
          pulse_count_next = pc_inc;
        end else begin
          if (pc < fw) first_width_next = pc;
          settle_count_next = '0;
        end
      end
      PH_SETTLE: begin
        settle_count_next = sc_inc;
        if (settled) begin
          res_valid = 1'b1;
          if (too_short) begin
            res_status = ST_SHORT;
          end else begin
            res_divisor = div_sat;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      timeout_count <= '0;
      pulse_count   <= '0;
      first_width   <= '0;
      settle_count  <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      timeout_count <= timeout_count_next;
      pulse_count   <= pulse_count_next;
      first_width   <= first_width_next;
      settle_count  <= settle_count_next;
    end
  end

  // output register plus skid register
  logic                 skid_valid;
  logic [M_DATA_W-1:0]  skid_data;
  logic [M_DATA_W-1:0]  res_data;
  logic                 res_push;

  assign res_data = M_DATA_W'({res_status, res_divisor});
  assign res_push = accept && res_valid;
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tvalid && !m_tready) begin
      if (res_push) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      m_tvalid   <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      m_tvalid <= res_push;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && !m_tready) begin
      if (res_push) skid_data <= res_data;
    end else if (skid_valid) begin
      m_tdata <= skid_data;
    end else if (res_push) begin
      m_tdata <= res_data;
    end
  end

endmodule

// ===== test/tb_uart_autobaud_detector.sv =====
// testbench for the uart auto-baud detector: directed and random line samples, checked per item
`timescale 1ns / 1ps

module tb_uart_autobaud_detector;
  import uab_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [DIV_W-1:0] divisor;
    status_t          status;
  } baud_result_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata;   // [0] rx_level, [1] restart, rest zero
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_DATA_W-1:0]  m_tdata;   // [12:0] divisor, [14:13] status, rest zero
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  uart_autobaud_detector dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted detector state and register copies
  phase_t                     ph;
  logic [31:0]                idle_ticks;
  logic [COUNT_WIDTH_DEF-1:0] pulse_len;
  logic [COUNT_WIDTH_DEF-1:0] bit_time;
  logic [19:0]                settle_ticks;
  logic [CFG_W-1:0]           cfg_timeout;
  logic                       cfg_ds;

  baud_result_t expected_baud[$];
  int err_count = 0;
  int sample_count = 0;
  int result_count = 0;
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("uart_autobaud_detector verification failed");
    $finish;
  end

  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void clear_detect();
    ph = PH_IDLE;
    idle_ticks = '0;
    pulse_len = '0;
    bit_time = '0;
    settle_ticks = '0;
  endfunction

  // advance the predicted detector by one line sample
  function automatic bit detect_step(input bit level, input bit restart,
                                     output baud_result_t res);
    logic [COUNT_WIDTH_DEF-1:0] d;
    bit keep;
    bit hit;
    hit = 1'b0;
    res = '{divisor: '0, status: ST_OK};
    if (restart) clear_detect();
    case (ph)
      PH_IDLE: begin
        if (!level) begin
          ph = PH_WAIT_HIGH;
        end else begin
          if (idle_ticks != '1) idle_ticks++;
          if (idle_ticks >= cfg_timeout) begin
            res.status = ST_TIMEOUT;
            ph = PH_DONE;
            hit = 1'b1;
          end
        end
      end
      PH_WAIT_HIGH: if (level) ph = PH_WAIT_LOW;
      PH_WAIT_LOW: begin
        if (!level) begin
          pulse_len = COUNT_WIDTH_DEF'(1);
          ph = PH_MEAS_A;
        end
      end
      PH_MEAS_A: begin
        if (!level) begin
          if (pulse_len != '1) pulse_len++;
        end else begin
          bit_time = pulse_len;
          pulse_len = '0;
          ph = PH_WAIT_LOW2;
        end
      end
      PH_WAIT_LOW2: begin
        if (!level) begin
          pulse_len = COUNT_WIDTH_DEF'(1);
          ph = PH_MEAS_B;
        end
      end
      PH_MEAS_B: begin
        if (!level) begin
          if (pulse_len != '1) pulse_len++;
        end else begin
          if (pulse_len < bit_time) bit_time = pulse_len;
          settle_ticks = '0;
          ph = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        settle_ticks++;
        if (settle_ticks >= 20'(bit_time) * SETTLE_BIT_TIMES_DEF) begin
          if (cfg_ds) begin
            d = bit_time >> SHIFT_DS;
            keep = bit_time[KEEP_DS];
          end else begin
            d = bit_time >> SHIFT_NS;
            keep = bit_time[KEEP_NS];
          end
          if (!keep && d == 0) begin
            res.status = ST_SHORT;
          end else begin
            if (!keep) d--;
            res.divisor = (d > DIV_MAX) ? DIV_MAX : d[DIV_W-1:0];
          end
          ph = PH_DONE;
          hit = 1'b1;
        end
      end
      default: ;
    endcase
    return hit;
  endfunction

  task automatic send_sample(input bit level, input bit restart);
    int gap;
    baud_result_t res;
    gap = pick_gap(idle_on);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= S_DATA_W'({restart, level});
    do @(posedge clk); while (!s_tready);
    sample_count++;
    if (detect_step(level, restart, res)) expected_baud.push_back(res);
  endtask

  // one sync character: idle highs, resync, two low pulses, then settle
  task automatic send_run(input bit with_restart, input int pre, input int lo0,
                          input int hi0, input int w1, input int mid, input int w2);
    send_sample(pre > 0, with_restart);
    repeat (pre - 1) send_sample(1'b1, 1'b0);
    repeat (lo0) send_sample(1'b0, 1'b0);
    repeat (hi0) send_sample(1'b1, 1'b0);
    repeat (w1) send_sample(1'b0, 1'b0);
    repeat (mid) send_sample(1'b1, 1'b0);
    repeat (w2) send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    while (ph == PH_SETTLE) send_sample(1'($urandom_range(0, 1)), 1'b0);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (expected_baud.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TIMEOUT_TICKS) cfg_timeout = value;
    else if (idx == REG_DOUBLE_SPEED) cfg_ds = value[0];
    @(posedge clk);
  endtask

  task automatic test_default_config();
    send_run(1'b1, 3, 1, 1, 6, 2, 9);
    send_run(1'b1, 2, 2, 1, 12, 3, 20);
    wait_drain();
  endtask

  task automatic test_timeout();
    write_reg(REG_TIMEOUT_TICKS, 32'd5);
    // times out in the first wait, the rest is ignored once done
    send_run(1'b1, 10, 1, 1, 8, 2, 8);
    wait_drain();
    write_reg(REG_TIMEOUT_TICKS, 32'd0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b0);
    wait_drain();
    write_reg(REG_TIMEOUT_TICKS, 32'd1);
    // later waits have no timeout
    send_sample(1'b0, 1'b1);
    send_run(1'b0, 0, 10, 10, 8, 12, 8);
    wait_drain();
    write_reg(REG_TIMEOUT_TICKS, 32'hffff_ffff);
    send_run(1'b1, 40, 1, 1, 16, 2, 16);
    wait_drain();
  endtask

  task automatic test_rounding();
    int ds_w1[6] = '{3, 4, 8, 15, 40, 200};
    int ds_w2[6] = '{3, 9, 8, 30, 13, 250};
    int ns_w1[6] = '{7, 8, 16, 24, 5, 250};
    int ns_w2[6] = '{7, 8, 16, 60, 50, 250};
    write_reg(REG_TIMEOUT_TICKS, 32'd1000);
    write_reg(REG_DOUBLE_SPEED, {31'($urandom()), 1'b1});
    foreach (ds_w1[i]) send_run(1'b1, 2, 1, 1, ds_w1[i], 2, ds_w2[i]);
    wait_drain();
    write_reg(REG_DOUBLE_SPEED, {31'($urandom()), 1'b0});
    foreach (ns_w1[i]) send_run(1'b1, 2, 1, 1, ns_w1[i], 2, ns_w2[i]);
    wait_drain();
  endtask

  task automatic test_unused_index();
    write_reg(REG_DOUBLE_SPEED, 32'd1);
    write_reg(REG_UNUSED, 32'd0);
    send_run(1'b1, 3, 1, 1, 15, 2, 15);
    wait_drain();
  endtask

  task automatic test_restart();
    // abandon a run in the first pulse
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    repeat (3) send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b1);
    // abandon a run while settling, restarting on a low sample
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    repeat (9) send_sample(1'b0, 1'b0);
    repeat (2) send_sample(1'b1, 1'b0);
    repeat (9) send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    repeat (20) send_sample(1'($urandom_range(0, 1)), 1'b0);
    send_sample(1'b0, 1'b1);
    send_run(1'b0, 0, 1, 2, 11, 1, 11);
    // after the result the line is ignored
    repeat (6) send_sample(1'($urandom_range(0, 1)), 1'b0);
    wait_drain();
  endtask

  function automatic int pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(1, 24);
    if (r < 97) return $urandom_range(25, 160);
    return $urandom_range(161, 600);
  endfunction

  task automatic reconfigure();
    int r;
    logic [CFG_W-1:0] t;
    r = $urandom_range(0, 5);
    case (r)
      0: t = '0;
      1: t = 32'd1;
      2: t = $urandom_range(2, 30);
      3: t = $urandom_range(31, 3000);
      4: t = 32'hffff_ffff;
      default: t = $urandom();
    endcase
    wait_drain();
    if ($urandom_range(0, 1)) write_reg(REG_TIMEOUT_TICKS, t);
    if ($urandom_range(0, 1)) write_reg(REG_DOUBLE_SPEED, $urandom());
    if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom());
  endtask

  task automatic test_random();
    int first_sample;
    first_sample = sample_count;
    while (sample_count - first_sample < 1150) begin
      idle_on = $urandom_range(0, 9) < 7;
      stall_on = $urandom_range(0, 9) < 7;
      if ($urandom_range(0, 3) == 0) reconfigure();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 20))
          send_sample(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
      end else begin
        send_run($urandom_range(0, 19) != 0, $urandom_range(0, 12), $urandom_range(1, 3),
                 $urandom_range(1, 3), pick_width(), $urandom_range(1, 6), pick_width());
      end
    end
    wait_drain();
  endtask

  // receiver side: ready with random stalls
  initial begin
    int hold;
    forever begin
      hold = pick_gap(stall_on);
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    baud_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (expected_baud.size() == 0) begin
        $error("unexpected result item: divisor %0d status %0d",
               m_tdata[DIV_W-1:0], m_tdata[DIV_W +: STATUS_W]);
        err_count++;
      end else begin
        want = expected_baud.pop_front();
        if (m_tdata[DIV_W-1:0] !== want.divisor) begin
          $error("divisor: expected %0d, actual %0d", want.divisor, m_tdata[DIV_W-1:0]);
          err_count++;
        end
        if (m_tdata[DIV_W +: STATUS_W] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status,
                 m_tdata[DIV_W +: STATUS_W]);
          err_count++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    cfg_timeout = TIMEOUT_RESET;
    cfg_ds = 1'b1;
    clear_detect();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_default_config();
    test_timeout();
    test_rounding();
    test_unused_index();
    test_restart();
    test_random();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("uart_autobaud_detector verification clean");
    end else begin
      $display("uart_autobaud_detector verification failed");
    end
    $finish;
  end

endmodule

// ===== uart_autobaud_detector.f =====
rtl/core/uab_pkg.sv
rtl/core/uart_autobaud_detector.sv
test/tb_uart_autobaud_detector.sv
